### rtl/bitmap_range_allocator_assert.svh
// Assertion helpers for the bitmap range allocator.
// Both expect clk and rst_n in scope.
`ifndef BITMAP_RANGE_ALLOCATOR_ASSERT_SVH
`define BITMAP_RANGE_ALLOCATOR_ASSERT_SVH

`define BRA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define BRA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bra_pkg.sv
`timescale 1ns / 1ps

package bra_pkg;

  localparam int MAP_BITS   = 1024;
  localparam int WORD_BITS  = 64;
  localparam int NUM_WORDS  = MAP_BITS / WORD_BITS;
  localparam int WORD_IDX_W = $clog2(NUM_WORDS);
  localparam int BIT_IDX_W  = $clog2(WORD_BITS);
  localparam int CNT_W      = $clog2(WORD_BITS + 1);

  // Field widths of the request and response.
  localparam int OP_W    = 3;
  localparam int START_W = 10;
  localparam int LEN_W   = 11;
  localparam int LIMIT_W = 11;
  localparam int AMASK_W = 10;
  localparam int VALUE_W = 12;

  // Bit positions and ends are carried at the response width, which holds
  // every aligned index plus length without wrapping.
  localparam int POS_W = VALUE_W;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [POS_W-1:0]     pos_t;

  localparam pos_t MAP_END = POS_W'(MAP_BITS);

  typedef enum logic [OP_W-1:0] {
    OP_SET        = 3'd0,
    OP_CLEAR      = 3'd1,
    OP_TEST_CLEAR = 3'd2,
    OP_FIND_ZERO  = 3'd3,
    OP_COUNT      = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RANGE,
    ST_COUNT,
    ST_SCAN0,
    ST_ALIGN,
    ST_SCAN1,
    ST_DONE
  } state_t;

  // Command to the word unit: the current bit window [pos, hi).
  typedef struct packed {
    pos_t pos;
    pos_t hi;
    logic want_one;
    logic set_bits;
  } wu_cmd_t;

  typedef struct packed {
    logic             empty;
    logic             hit;
    pos_t             hit_pos;
    logic             any_set;
    logic [CNT_W-1:0] ones;
    word_t            wr_word;
    pos_t             next_pos;
  } wu_res_t;

endpackage

### rtl/bra_ifs.sv
`timescale 1ns / 1ps

interface bra_req_if import bra_pkg::*;;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [START_W-1:0] start_req;
  logic [LEN_W-1:0]   length;
  logic [LIMIT_W-1:0] limit;
  logic [AMASK_W-1:0] aln_mask;

  modport source (output valid, op, start_req, length, limit, aln_mask, input ready);
  modport sink   (input valid, op, start_req, length, limit, aln_mask, output ready);
endinterface

interface bra_rsp_if import bra_pkg::*;;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               flag;

  modport source (output valid, value, flag, input ready);
  modport sink   (input valid, value, flag, output ready);
endinterface

### rtl/bitmap_range_allocator.sv
`timescale 1ns / 1ps
// Bitmap range allocator: a 1024-bit map kept as sixteen 64-bit words,
// all clear after reset.
// Requests arrive on in_req (valid/ready) with op, start_req, length, limit
// and aln_mask; each request yields exactly one response on out_rsp
// (valid/ready) with value and flag.
// One word unit does all the work, one map word per cycle: it masks the
// word to the current bit window, finds the first set or clear bit, counts
// ones and forms the rewritten word for set and clear.
// Set, clear, test-and-clear and count step through the words touched and
// then load the response. Find zero area scans words for a clear bit, then
// aligns each candidate and checks it for set bits; each blocked candidate
// restarts the scan after the blocking bit, so a search on a badly fragmented
// map runs far longer than one on a sparse map.
// in_req.ready is high only while no request is in progress. A finished
// response sits in an output register, so the next request is taken while
// the receiver stalls; a response that finds that register still full waits
// until it drains.
// Reset (rst_n low, synchronous) clears the map and drops any request or
// response in flight.

`include "bitmap_range_allocator_assert.svh"

module bitmap_range_allocator import bra_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  bra_req_if.sink   in_req,
  bra_rsp_if.source out_rsp
);

  state_t              state_r, state_nxt;
  pos_t                pos_r, pos_nxt;
  pos_t                hi_r, hi_nxt;
  pos_t                size_r, size_nxt;
  pos_t                idx_r, idx_nxt;
  pos_t                acc_r, acc_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [AMASK_W-1:0]  am_r, am_nxt;
  logic                flag_r, flag_nxt;
  logic                set_bits_r, set_bits_nxt;
  logic                tc_r, tc_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]  out_value_r, out_value_nxt;
  logic                out_flag_r, out_flag_nxt;

  logic    in_fire;
  logic    out_free;
  logic    map_wr_en;
  wu_cmd_t wu_cmd;
  wu_res_t wu_res;
  word_t   map_word;

  pos_t start_ext, len_ext, lim_ext, range_end, clip_end, lim_size, cnt_end;
  pos_t aligned, area_end;

  assign in_req.ready  = (state_r == ST_IDLE);
  assign in_fire       = in_req.valid && in_req.ready;
  assign out_free      = !out_valid_r || out_rsp.ready;
  assign out_rsp.valid = out_valid_r;
  assign out_rsp.value = out_value_r;
  assign out_rsp.flag  = out_flag_r;

  assign wu_cmd.pos      = pos_r;
  assign wu_cmd.hi       = hi_r;
  assign wu_cmd.want_one = (state_r == ST_SCAN1);
  assign wu_cmd.set_bits = set_bits_r;

  bra_map u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (pos_r[BIT_IDX_W +: WORD_IDX_W]),
    .rd_word (map_word),
    .wr_en   (map_wr_en),
    .wr_addr (pos_r[BIT_IDX_W +: WORD_IDX_W]),
    .wr_data (wu_res.wr_word)
  );

  bra_word_unit u_word_unit (
    .cmd     (wu_cmd),
    .rd_word (map_word),
    .res     (wu_res)
  );

  // Request decode and alignment arithmetic.
  always_comb begin
    start_ext = pos_t'(in_req.start_req);
    len_ext   = pos_t'(in_req.length);
    lim_ext   = pos_t'(in_req.limit);
    range_end = start_ext + len_ext;
    clip_end  = (range_end > MAP_END) ? MAP_END : range_end;
    lim_size  = (lim_ext > MAP_END) ? MAP_END : lim_ext;
    cnt_end   = (len_ext > MAP_END) ? MAP_END : len_ext;
    aligned   = (idx_r + pos_t'(am_r)) & ~pos_t'(am_r);
    area_end  = aligned + pos_t'(len_r);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_req.op)
            OP_SET, OP_CLEAR, OP_TEST_CLEAR: state_nxt = ST_RANGE;
            OP_COUNT:                        state_nxt = ST_COUNT;
            OP_FIND_ZERO:                    state_nxt = ST_SCAN0;
            default:                         state_nxt = ST_DONE;
          endcase
        end
      end
      ST_RANGE, ST_COUNT: begin
        if (wu_res.empty) begin
          state_nxt = ST_DONE;
        end
      end
      ST_SCAN0: begin
        if (wu_res.empty || wu_res.hit) begin
          state_nxt = ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        state_nxt = (area_end > size_r) ? ST_DONE : ST_SCAN1;
      end
      ST_SCAN1: begin
        if (wu_res.empty) begin
          state_nxt = ST_DONE;
        end else if (wu_res.hit) begin
          state_nxt = ST_SCAN0;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    pos_nxt       = pos_r;
    hi_nxt        = hi_r;
    size_nxt      = size_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    len_nxt       = len_r;
    am_nxt        = am_r;
    flag_nxt      = flag_r;
    set_bits_nxt  = set_bits_r;
    tc_nxt        = tc_r;
    out_value_nxt = out_value_r;
    out_flag_nxt  = out_flag_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    map_wr_en     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          acc_nxt      = '0;
          flag_nxt     = 1'b0;
          len_nxt      = in_req.length;
          am_nxt       = in_req.aln_mask;
          size_nxt     = lim_size;
          set_bits_nxt = (in_req.op == OP_SET);
          tc_nxt       = (in_req.op == OP_TEST_CLEAR);
          case (in_req.op)
            OP_SET, OP_CLEAR, OP_TEST_CLEAR: begin
              pos_nxt = start_ext;
              hi_nxt  = clip_end;
            end
            OP_COUNT: begin
              pos_nxt = '0;
              hi_nxt  = cnt_end;
            end
            OP_FIND_ZERO: begin
              pos_nxt = start_ext;
              hi_nxt  = lim_size;
            end
            default: ;
          endcase
        end
      end
      ST_RANGE: begin
        if (!wu_res.empty) begin
          map_wr_en = 1'b1;
          flag_nxt  = flag_r | (tc_r & wu_res.any_set);
          pos_nxt   = wu_res.next_pos;
        end
      end
      ST_COUNT: begin
        if (!wu_res.empty) begin
          acc_nxt = acc_r + pos_t'(wu_res.ones);
          pos_nxt = wu_res.next_pos;
        end
      end
      ST_SCAN0: begin
        // No clear bit below the size makes the size itself the candidate.
        if (wu_res.empty) begin
          idx_nxt = hi_r;
        end else if (wu_res.hit) begin
          idx_nxt = wu_res.hit_pos;
        end else begin
          pos_nxt = wu_res.next_pos;
        end
      end
      ST_ALIGN: begin
        if (area_end > size_r) begin
          acc_nxt  = area_end;
          flag_nxt = 1'b0;
        end else begin
          idx_nxt = aligned;
          pos_nxt = aligned;
          hi_nxt  = area_end;
        end
      end
      ST_SCAN1: begin
        if (wu_res.empty) begin
          acc_nxt  = idx_r;
          flag_nxt = 1'b1;
        end else if (wu_res.hit) begin
          // A set bit inside the candidate area: search again just past it.
          pos_nxt = wu_res.hit_pos + pos_t'(1);
          hi_nxt  = size_r;
        end else begin
          pos_nxt = wu_res.next_pos;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = acc_r;
          out_flag_nxt  = flag_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    hi_r        <= hi_nxt;
    size_r      <= size_nxt;
    idx_r       <= idx_nxt;
    acc_r       <= acc_nxt;
    len_r       <= len_nxt;
    am_r        <= am_nxt;
    flag_r      <= flag_nxt;
    set_bits_r  <= set_bits_nxt;
    tc_r        <= tc_nxt;
    out_value_r <= out_value_nxt;
    out_flag_r  <= out_flag_nxt;
  end

  `BRA_ASSERT_SAME(a_map_write_in_range, map_wr_en, state_r == ST_RANGE, "stray map write")
  `BRA_ASSERT_NEXT(a_accept_leaves_idle, in_fire, state_r != ST_IDLE, "request not started")
  `BRA_ASSERT_SAME(a_area_within_size, state_r == ST_SCAN1, hi_r <= size_r, "area past size")
  `BRA_ASSERT_NEXT(a_done_loads_output, (state_r == ST_DONE) && out_free, out_valid_r, "not loaded")

endmodule

### rtl/bra_map.sv
`timescale 1ns / 1ps

module bra_map import bra_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [WORD_IDX_W-1:0] rd_addr,
  output word_t                 rd_word,
  input  logic                  wr_en,
  input  logic [WORD_IDX_W-1:0] wr_addr,
  input  word_t                 wr_data
);

  word_t words_r [NUM_WORDS];

  assign rd_word = words_r[rd_addr];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_WORDS; k++) begin
        words_r[k] <= '0;
      end
    end else if (wr_en) begin
      words_r[wr_addr] <= wr_data;
    end
  end

endmodule

### rtl/bra_word_unit.sv
`timescale 1ns / 1ps

module bra_word_unit import bra_pkg::*; (
  input  wu_cmd_t cmd,
  input  word_t   rd_word,
  output wu_res_t res
);

  logic [BIT_IDX_W-1:0] lo_off;
  logic [BIT_IDX_W-1:0] ffs;
  logic [CNT_W-1:0]     cnt;
  pos_t                 base;
  pos_t                 hi_rel;
  word_t                lo_mask;
  word_t                hi_mask;
  word_t                mask;
  word_t                set_in;
  word_t                sel;

  always_comb begin
    lo_off  = cmd.pos[BIT_IDX_W-1:0];
    base    = {cmd.pos[POS_W-1:BIT_IDX_W], {BIT_IDX_W{1'b0}}};
    hi_rel  = cmd.hi - base;
    lo_mask = {WORD_BITS{1'b1}} << lo_off;
    // The window ends inside this word only when hi is less than a word away.
    if (hi_rel >= pos_t'(WORD_BITS)) begin
      hi_mask = {WORD_BITS{1'b1}};
    end else begin
      hi_mask = ~({WORD_BITS{1'b1}} << hi_rel[BIT_IDX_W-1:0]);
    end
    mask   = lo_mask & hi_mask;
    set_in = rd_word & mask;
    sel    = cmd.want_one ? set_in : (~rd_word & mask);

    ffs = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (sel[i]) begin
        ffs = BIT_IDX_W'(i);
      end
    end

    cnt = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      cnt = cnt + CNT_W'(set_in[i]);
    end

    res.empty    = (cmd.pos >= cmd.hi);
    res.hit      = |sel;
    res.hit_pos  = base | pos_t'(ffs);
    res.any_set  = |set_in;
    res.ones     = cnt;
    res.wr_word  = cmd.set_bits ? (rd_word | mask) : (rd_word & ~mask);
    res.next_pos = base + pos_t'(WORD_BITS);
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import bra_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int RANDOM_ITEMS  = 800;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_REPORTS   = 10;
  // A search on a badly fragmented map can be very slow; the limit allows
  // every request to be that slow, with stalls, several times.
  localparam longint LIMIT_CYCLES = 20_000_000;

  // Op codes the block does not implement.
  localparam logic [OP_W-1:0] OP_RSVD_LO  = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_HI  = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [START_W-1:0] start_req;
    logic [LEN_W-1:0]   length;
    logic [LIMIT_W-1:0] limit;
    logic [AMASK_W-1:0] aln_mask;
  } alloc_req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               flag;
  } alloc_rsp_t;

  typedef struct packed {
    alloc_req_t req;
    logic       known;
    alloc_rsp_t rsp;
  } dir_row_t;

  typedef struct {
    logic [START_W-1:0] base;
    logic [LEN_W-1:0]   span;
  } block_t;

  // Rows marked known carry the response typed in; the others go through
  // the map predictor.
  localparam dir_row_t DIR_TAB [24] = '{
    '{'{OP_COUNT,      10'd0,    11'd1024, 11'd0,    10'd0},    1'b1, '{12'd0,    1'b0}},
    '{'{OP_FIND_ZERO,  10'd0,    11'd0,    11'd0,    10'd0},    1'b1, '{12'd0,    1'b1}},
    '{'{OP_FIND_ZERO,  10'd5,    11'd16,   11'd1024, 10'd7},    1'b1, '{12'd8,    1'b1}},
    '{'{OP_SET,        10'd0,    11'd1024, 11'd0,    10'd0},    1'b1, '{12'd0,    1'b0}},
    '{'{OP_COUNT,      10'd0,    11'd1024, 11'd0,    10'd0},    1'b1, '{12'd1024, 1'b0}},
    '{'{OP_FIND_ZERO,  10'd0,    11'd1,    11'd1024, 10'd0},    1'b1, '{12'd1025, 1'b0}},
    '{'{OP_TEST_CLEAR, 10'd1000, 11'd1024, 11'd0,    10'd0},    1'b1, '{12'd0,    1'b1}},
    '{'{OP_TEST_CLEAR, 10'd1000, 11'd1024, 11'd0,    10'd0},    1'b1, '{12'd0,    1'b0}},
    '{'{OP_COUNT,      10'd0,    11'd2047, 11'd0,    10'd0},    1'b1, '{12'd1000, 1'b0}},
    '{'{OP_CLEAR,      10'd512,  11'd64,   11'd0,    10'd0},    1'b1, '{12'd0,    1'b0}},
    '{'{OP_FIND_ZERO,  10'd0,    11'd64,   11'd1024, 10'd63},   1'b0, '{12'd0,    1'b0}},
    '{'{OP_FIND_ZERO,  10'd0,    11'd100,  11'd2047, 10'd0},    1'b0, '{12'd0,    1'b0}},
    '{'{OP_SET,        10'd1023, 11'd0,    11'd0,    10'd0},    1'b1, '{12'd0,    1'b0}},
    '{'{OP_SET,        10'd1023, 11'd2047, 11'd0,    10'd0},    1'b1, '{12'd0,    1'b0}},
    '{'{OP_RSVD_LO,    10'd1023, 11'd2047, 11'd2047, 10'd1023}, 1'b1, '{12'd0,    1'b0}},
    '{'{OP_RSVD_MID,   10'd0,    11'd0,    11'd0,    10'd0},    1'b1, '{12'd0,    1'b0}},
    '{'{OP_RSVD_HI,    10'd1023, 11'd2047, 11'd2047, 10'd1023}, 1'b1, '{12'd0,    1'b0}},
    '{'{OP_FIND_ZERO,  10'd3,    11'd8,    11'd1024, 10'h2aa},  1'b0, '{12'd0,    1'b0}},
    '{'{OP_FIND_ZERO,  10'd1023, 11'd5,    11'd0,    10'd0},    1'b1, '{12'd5,    1'b0}},
    '{'{OP_FIND_ZERO,  10'd1023, 11'd1,    11'd1024, 10'd0},    1'b0, '{12'd0,    1'b0}},
    '{'{OP_FIND_ZERO,  10'd1,    11'd0,    11'd2047, 10'd1023}, 1'b0, '{12'd0,    1'b0}},
    '{'{OP_TEST_CLEAR, 10'd0,    11'd0,    11'd0,    10'd0},    1'b1, '{12'd0,    1'b0}},
    '{'{OP_COUNT,      10'd0,    11'd0,    11'd0,    10'd0},    1'b1, '{12'd0,    1'b0}},
    '{'{OP_CLEAR,      10'd0,    11'd2047, 11'd0,    10'd0},    1'b1, '{12'd0,    1'b0}}
  };

  logic clk;
  logic rst_n;

  bra_req_if in_req ();
  bra_rsp_if out_rsp ();

  bitmap_range_allocator dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  logic [MAP_BITS-1:0] alloc_map = '0;
  alloc_rsp_t          expected_rsp [$];
  block_t              live_blocks [$];
  bit                  idling;
  bit                  use_known;
  alloc_rsp_t          known_rsp;
  int                  n_mismatch = 0;
  int                  n_checked = 0;
  int                  n_req = 0;
  int                  n_finds = 0;
  int                  n_found = 0;
  longint              cycle_count = 0;

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // First index in [from, size) whose bit equals want, or size if none.
  function automatic int scan_map(int size, int from, logic want);
    for (int i = from; i < size; i++) begin
      if ((i < MAP_BITS ? alloc_map[i] : 1'b0) == want) return i;
    end
    return size;
  endfunction

  function automatic void find_area(input alloc_req_t r, output logic [VALUE_W-1:0] at,
                                    output logic ok);
    int  size;
    int  from;
    int  idx;
    int  last;
    int  hit;
    bit  done;
    size = (int'(r.limit) > MAP_BITS) ? MAP_BITS : int'(r.limit);
    from = int'(r.start_req);
    done = 1'b0;
    at   = '0;
    ok   = 1'b0;
    while (!done) begin
      idx  = scan_map(size, from, 1'b0);
      idx  = (idx + int'(r.aln_mask)) & ~int'(r.aln_mask);
      last = idx + int'(r.length);
      if (last > size) begin
        at   = VALUE_W'(last);
        done = 1'b1;
      end else begin
        hit = scan_map(last, idx, 1'b1);
        if (hit < last) begin
          from = hit + 1;
        end else begin
          at   = VALUE_W'(idx);
          ok   = 1'b1;
          done = 1'b1;
        end
      end
    end
  endfunction

  // Applies one request to the map and returns the response it should give.
  function automatic alloc_rsp_t apply_req(alloc_req_t r);
    alloc_rsp_t res;
    int         last;
    res = '0;
    case (r.op)
      OP_SET, OP_CLEAR, OP_TEST_CLEAR: begin
        last = int'(r.start_req) + int'(r.length);
        if (last > MAP_BITS) last = MAP_BITS;
        for (int i = int'(r.start_req); i < last; i++) begin
          if (r.op == OP_TEST_CLEAR && alloc_map[i]) res.flag = 1'b1;
          alloc_map[i] = (r.op == OP_SET);
        end
      end
      OP_FIND_ZERO: find_area(r, res.value, res.flag);
      OP_COUNT: begin
        last = (int'(r.length) > MAP_BITS) ? MAP_BITS : int'(r.length);
        for (int i = 0; i < last; i++) res.value += VALUE_W'(alloc_map[i]);
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void log_mismatch(string what, alloc_rsp_t want, alloc_rsp_t got);
    n_mismatch++;
    if (n_mismatch <= MAX_REPORTS) begin
      $display("Mismatch (%s) cycle %0d: want value %0d flag %0b, got value %0d flag %0b",
               what, cycle_count, want.value, want.flag, got.value, got.flag);
    end
  endfunction

  function automatic logic [AMASK_W-1:0] rand_mask();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return AMASK_W'($urandom);
    if (pick < 85) return AMASK_W'((1 << $urandom_range(0, 6)) - 1);
    return AMASK_W'((1 << $urandom_range(7, AMASK_W)) - 1);
  endfunction

  function automatic alloc_req_t rand_noise();
    alloc_req_t r;
    int         pick;
    if ($urandom_range(0, 99) < 6) begin
      r.op = OP_W'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
    end else begin
      r.op = OP_W'($urandom_range(OP_SET, OP_COUNT));
    end
    r.start_req = START_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 70) r.length = LEN_W'($urandom_range(1, 32));
    else if (pick < 90) r.length = LEN_W'($urandom_range(0, MAP_BITS));
    else r.length = LEN_W'($urandom);
    r.limit = ($urandom_range(0, 99) < 70) ? LIMIT_W'(MAP_BITS) : LIMIT_W'($urandom);
    r.aln_mask = rand_mask();
    return r;
  endfunction

  // Called just after a falling edge; returns just after the falling edge
  // that follows acceptance, so valid is never lowered and raised at once.
  task automatic drive_req(input alloc_req_t r, input logic known, input alloc_rsp_t rsp);
    if (idling && $urandom_range(0, 99) < 10) begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    use_known            = known;
    known_rsp            = rsp;
    in_req.valid        <= 1'b1;
    in_req.op           <= r.op;
    in_req.start_req    <= r.start_req;
    in_req.length       <= r.length;
    in_req.limit        <= r.limit;
    in_req.aln_mask     <= r.aln_mask;
    do @(posedge clk); while (!in_req.ready);
    @(negedge clk);
  endtask

  // Mostly allocate-then-free traffic, with random noise mixed in.
  task automatic run_random();
    alloc_req_t         r;
    alloc_rsp_t         none;
    logic [VALUE_W-1:0] at;
    logic               ok;
    int                 sent;
    int                 pick;
    int                 k;
    none = '0;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      idling = !(sent >= 300 && sent < 450);
      pick   = $urandom_range(0, 99);
      r      = rand_noise();
      if (pick < 35) begin
        r.op         = OP_FIND_ZERO;
        r.start_req  = ($urandom_range(0, 3) == 0) ? START_W'($urandom) : '0;
        r.length     = LEN_W'($urandom_range(1, 48));
        r.limit      = ($urandom_range(0, 4) == 0) ? LIMIT_W'($urandom) : LIMIT_W'(MAP_BITS);
        r.aln_mask   = rand_mask();
        drive_req(r, 1'b0, none);
        sent++;
        // A search leaves the map alone, so it can be redone here.
        find_area(r, at, ok);
        if (ok) begin
          r.op        = OP_SET;
          r.start_req = START_W'(at);
          drive_req(r, 1'b0, none);
          sent++;
          live_blocks.push_back('{START_W'(at), r.length});
        end
      end else if (pick < 65 && live_blocks.size() > 0) begin
        k           = $urandom_range(0, live_blocks.size() - 1);
        r.op        = $urandom_range(0, 1) ? OP_TEST_CLEAR : OP_CLEAR;
        r.start_req = live_blocks[k].base;
        r.length    = live_blocks[k].span;
        live_blocks.delete(k);
        drive_req(r, 1'b0, none);
        sent++;
      end else begin
        drive_req(r, 1'b0, none);
        if (r.op <= OP_COUNT) sent++;
      end
    end
  endtask

  always @(negedge clk) begin
    out_rsp.ready <= !(idling && $urandom_range(0, 99) < 10);
  end

  always @(posedge clk) begin : scoreboard
    alloc_req_t acc;
    alloc_rsp_t got;
    alloc_rsp_t want;
    if (rst_n) begin
      if (out_rsp.valid && out_rsp.ready) begin
        got.value = out_rsp.value;
        got.flag  = out_rsp.flag;
        n_checked++;
        if (expected_rsp.size() == 0) begin
          log_mismatch("response with no request waiting", '0, got);
        end else begin
          want = expected_rsp.pop_front();
          if (got.value !== want.value) log_mismatch("value", want, got);
          if (got.flag !== want.flag) log_mismatch("flag", want, got);
        end
      end
      if (in_req.valid && in_req.ready) begin
        acc.op         = in_req.op;
        acc.start_req  = in_req.start_req;
        acc.length     = in_req.length;
        acc.limit      = in_req.limit;
        acc.aln_mask   = in_req.aln_mask;
        want = apply_req(acc);
        expected_rsp.push_back(use_known ? known_rsp : want);
        n_req++;
        if (acc.op == OP_FIND_ZERO) begin
          n_finds++;
          n_found += int'(want.flag);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timed out after %0d cycles with %0d responses outstanding",
               cycle_count, expected_rsp.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_n              = 1'b0;
    in_req.valid       = 1'b0;
    in_req.op          = OP_SET;
    in_req.start_req   = '0;
    in_req.length      = '0;
    in_req.limit       = '0;
    in_req.aln_mask    = '0;
    idling             = 1'b1;
    use_known          = 1'b0;
    known_rsp          = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (DIR_TAB[i]) drive_req(DIR_TAB[i].req, DIR_TAB[i].known, DIR_TAB[i].rsp);
    run_random();
    in_req.valid <= 1'b0;
    idling = 1'b1;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d requests (%0d directed); %0d area searches, %0d found room.",
             n_req, $size(DIR_TAB), n_finds, n_found);
    $display("Checked %0d responses in %0d cycles; %0d field mismatches.",
             n_checked, cycle_count, n_mismatch);
    if (n_mismatch == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
